FILE: sv/rwd_pkg.sv
// ----------------------------------------------------------------------------
// rwd_pkg
// Shared types and constants of the readout word decoder: result kinds,
// sequencer states, STP assembly phases and the decoded word record.
// ----------------------------------------------------------------------------
package rwd_pkg;

    // ADC store geometry
    localparam int ADC_CHANNELS = 64;
    localparam int CH_W         = $clog2(ADC_CHANNELS);
    localparam int ADC_W        = 12;

    // Result kind codes
    typedef enum logic [3:0] {
        KIND_OLD_HDR  = 4'd0,
        KIND_NEW_HDR  = 4'd1,
        KIND_ADC_HG   = 4'd2,
        KIND_ADC_LG   = 4'd3,
        KIND_TDC_LEAD = 4'd4,
        KIND_TDC_TRL  = 4'd5,
        KIND_SCALER   = 4'd6,
        KIND_STP1     = 4'd7,
        KIND_STP2     = 4'd8,
        KIND_STP3     = 4'd9,
        KIND_STP_ERR  = 4'd10,
        KIND_UNKNOWN  = 4'd11
    } kind_t;

    // Record dump sequencer
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_EMIT = 2'd2
    } state_t;

    // STP assembly phase
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    // One decoded word
    typedef struct packed {
        logic              is_hdr;
        logic              hdr_new;
        logic              is_hg;
        logic              is_lg;
        logic              is_stp;
        logic              is_dump;
        kind_t             kind;
        logic [6:0]        channel;
        logic [13:0]       value;
        logic              otr;
        logic [CH_W-1:0]   adc_ch;
        logic [ADC_W-1:0]  adc_val;
        logic [11:0]       stp_events;
        logic              stp_command;
        logic [23:0]       stp_low24;
    } dec_t;

endpackage

FILE: sv/rwd_ram.sv
// ----------------------------------------------------------------------------
// rwd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rwd_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/rwd_decode.sv
// ----------------------------------------------------------------------------
// rwd_decode
// Byte-swaps one readout word and classifies it in priority order for the
// legacy or the new format; extracts channel, value and STP fields.
// ----------------------------------------------------------------------------
module rwd_decode import rwd_pkg::*; (
    input  logic [31:0] raw_word,
    input  logic        new_format,
    output dec_t        dec
);

    logic [31:0] d;
    logic        hdr_old, hdr_new;
    logic        hg, lg, lead, trail, scal, stp;
    logic [CH_W-1:0] adc_ch;
    logic [6:0]  scal_ch;

    // big-endian to native
    assign d = {raw_word[7:0], raw_word[15:8], raw_word[23:16], raw_word[31:24]};

    assign hdr_old = (d & 32'hfffff000) == 32'h0ffff000;
    assign hdr_new = (d & 32'hffff0000) == 32'hff7c0000;

    // per-format class patterns
    always_comb begin
        if (new_format) begin
            hg    = (d & 32'hffc00000) == 32'hc0000000;
            lg    = (d & 32'hffc00000) == 32'hc0400000;
            lead  = d[31:24] == 8'hc1;
            trail = 1'b0;   // leading pattern shadows it
            scal  = d[31:24] == 8'hc2;
            stp   = d[31:24] == 8'hc3;
        end else begin
            hg    = (d & 32'h00680000) == 32'h00000000;
            lg    = (d & 32'h00680000) == 32'h00080000;
            lead  = (d & 32'h00601000) == 32'h00201000;
            trail = (d & 32'h00601000) == 32'h00200000;
            scal  = (d & 32'h00600000) == 32'h00400000;
            stp   = (d & 32'h00600000) == 32'h00600000;
        end
    end

    assign adc_ch  = new_format ? d[16 +: CH_W] : d[13 +: CH_W];
    assign scal_ch = new_format ? d[22:16] : d[20:14];

    // priority classification
    always_comb begin
        dec             = '0;
        dec.adc_ch      = adc_ch;
        dec.adc_val     = d[ADC_W-1:0];
        dec.stp_events  = d[11:0];
        dec.stp_command = d[16];
        dec.stp_low24   = d[23:0];
        priority if (hdr_old || hdr_new) begin
            dec.is_hdr  = 1'b1;
            dec.hdr_new = hdr_new;
            dec.kind    = hdr_old ? KIND_OLD_HDR : KIND_NEW_HDR;
            dec.value   = {2'b00, d[11:0]};
        end else if (hg || lg) begin
            dec.is_hg   = hg;
            dec.is_lg   = !hg;
            dec.kind    = hg ? KIND_ADC_HG : KIND_ADC_LG;
            dec.channel = {{(7-CH_W){1'b0}}, adc_ch};
            dec.value   = {2'b00, d[11:0]};
            dec.otr     = d[12];
        end else if (lead || trail) begin
            dec.kind    = lead ? KIND_TDC_LEAD : KIND_TDC_TRL;
            dec.channel = {{(7-CH_W){1'b0}}, adc_ch};
            dec.value   = {2'b00, d[11:0]};
        end else if (scal) begin
            dec.kind    = KIND_SCALER;
            dec.channel = scal_ch;
            dec.value   = d[13:0];
        end else if (stp) begin
            dec.is_stp  = 1'b1;
            dec.is_dump = 1'b1;
            dec.kind    = KIND_STP1;
        end else begin
            dec.is_dump = 1'b1;
            dec.kind    = KIND_UNKNOWN;
        end
    end

endmodule

FILE: sv/readout_word_decoder_unit.sv
// ----------------------------------------------------------------------------
// readout_word_decoder_unit
// Readout word decoder: classifies byte-swapped readout words, keeps the
// event id and STP registers, stores ADC values in two 64-entry RAMs and
// dumps both stores as 64 record words on STP and unknown words.
// ----------------------------------------------------------------------------
// Header, ADC, TDC and scaler words give one result word each and are taken
// every cycle while the output register is free or being drained. STP and
// unknown words give 64 record words; each record is read from both RAMs in
// ST_READ and written to the output register in ST_EMIT, which waits out
// any output stall; no input word is taken until the last record is out. The
// two ADC stores are synchronous RAMs with a registered read port; a per-entry
// valid bit makes never-written entries read as zero right after reset.
// ----------------------------------------------------------------------------
module readout_word_decoder_unit import rwd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_raw_word,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_kind,
    output logic [6:0]  m_channel,
    output logic [13:0] m_value,
    output logic        m_out_of_range,
    output logic [31:0] m_event_id,
    output logic [11:0] m_hg_value,
    output logic [11:0] m_lg_value,
    output logic [11:0] m_stp_events,
    output logic        m_stp_command,
    output logic [23:0] m_stp_cycles,
    output logic [23:0] m_stp_tdc_count,
    output logic        m_last
);

    dec_t dec;

    state_t state_reg, state_next;
    logic [CH_W-1:0] idx_reg;
    kind_t  dump_kind_reg;
    logic   new_format_reg;
    logic [31:0] next_event_reg, cur_event_reg;
    phase_t stp_phase_reg;
    logic [11:0] stp_events_reg;
    logic        stp_command_reg;
    logic [23:0] stp_cycles_reg, stp_tdc_reg;
    logic [ADC_CHANNELS-1:0] hg_vld_reg, lg_vld_reg;
    logic        rd_hg_vld_reg, rd_lg_vld_reg;

    logic        m_valid_reg;
    kind_t       m_kind_reg;
    logic [6:0]  m_channel_reg;
    logic [13:0] m_value_reg;
    logic        m_otr_reg, m_last_reg;
    logic [11:0] m_hg_reg, m_lg_reg;

    logic out_free, accept, rd_en, emit, idx_last;
    logic [ADC_W-1:0] hg_rdata, lg_rdata;

    rwd_decode u_decode (
        .raw_word   (s_raw_word),
        .new_format (new_format_reg),
        .dec        (dec)
    );

    // ADC stores
    rwd_ram #(.WIDTH(ADC_W), .DEPTH(ADC_CHANNELS)) u_hg_ram (
        .aclk  (aclk),
        .we    (accept && dec.is_hg),
        .waddr (dec.adc_ch),
        .wdata (dec.adc_val),
        .re    (rd_en),
        .raddr (idx_reg),
        .rdata (hg_rdata)
    );

    rwd_ram #(.WIDTH(ADC_W), .DEPTH(ADC_CHANNELS)) u_lg_ram (
        .aclk  (aclk),
        .we    (accept && dec.is_lg),
        .waddr (dec.adc_ch),
        .wdata (dec.adc_val),
        .re    (rd_en),
        .raddr (idx_reg),
        .rdata (lg_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign idx_last = idx_reg == CH_W'(ADC_CHANNELS - 1);

    // sequencer outputs
    always_comb begin
        s_ready = 1'b0;
        rd_en   = 1'b0;
        emit    = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready = out_free;
            ST_READ: rd_en   = 1'b1;
            ST_EMIT: emit    = out_free;
            default: ;
        endcase
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept && dec.is_dump) state_next = ST_READ;
            ST_READ: state_next = ST_EMIT;
            ST_EMIT: if (emit) state_next = idx_last ? ST_IDLE : ST_READ;
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            new_format_reg  <= 1'b0;
            next_event_reg  <= '0;
            cur_event_reg   <= '0;
            stp_phase_reg   <= PH_FIRST;
            stp_events_reg  <= '0;
            stp_command_reg <= 1'b0;
            stp_cycles_reg  <= '0;
            stp_tdc_reg     <= '0;
            hg_vld_reg      <= '0;
            lg_vld_reg      <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                if (dec.is_hdr) begin
                    new_format_reg <= new_format_reg | dec.hdr_new;
                    cur_event_reg  <= next_event_reg;
                    next_event_reg <= next_event_reg + 32'd1;
                    stp_phase_reg  <= PH_FIRST;
                end
                if (dec.is_hg) hg_vld_reg[dec.adc_ch] <= 1'b1;
                if (dec.is_lg) lg_vld_reg[dec.adc_ch] <= 1'b1;
                // STP assembly
                if (dec.is_stp) begin
                    unique case (stp_phase_reg)
                        PH_FIRST: begin
                            stp_events_reg  <= dec.stp_events;
                            stp_command_reg <= dec.stp_command;
                            stp_phase_reg   <= PH_SECOND;
                        end
                        PH_SECOND: begin
                            stp_cycles_reg <= dec.stp_low24;
                            stp_phase_reg  <= PH_THIRD;
                        end
                        PH_THIRD: begin
                            stp_tdc_reg   <= dec.stp_low24;
                            stp_phase_reg <= PH_DONE;
                        end
                        PH_DONE: ;
                        default: ;
                    endcase
                end
                if (dec.is_dump) idx_reg <= '0;
            end
            if (emit) idx_reg <= idx_reg + CH_W'(1);
            // output register occupancy
            if (accept && !dec.is_dump) begin
                m_valid_reg <= 1'b1;
            end else if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // dump kind and store valid bits alongside the RAM read
    always_ff @(posedge aclk) begin
        if (accept && dec.is_dump) begin
            if (!dec.is_stp) begin
                dump_kind_reg <= KIND_UNKNOWN;
            end else begin
                unique case (stp_phase_reg)
                    PH_FIRST:  dump_kind_reg <= KIND_STP1;
                    PH_SECOND: dump_kind_reg <= KIND_STP2;
                    PH_THIRD:  dump_kind_reg <= KIND_STP3;
                    PH_DONE:   dump_kind_reg <= KIND_STP_ERR;
                    default:   dump_kind_reg <= KIND_STP_ERR;
                endcase
            end
        end
        if (rd_en) begin
            rd_hg_vld_reg <= hg_vld_reg[idx_reg];
            rd_lg_vld_reg <= lg_vld_reg[idx_reg];
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (accept && !dec.is_dump) begin
            m_kind_reg    <= dec.kind;
            m_channel_reg <= dec.channel;
            m_value_reg   <= dec.value;
            m_otr_reg     <= dec.otr;
            m_hg_reg      <= '0;
            m_lg_reg      <= '0;
            m_last_reg    <= 1'b1;
        end else if (emit) begin
            m_kind_reg    <= dump_kind_reg;
            m_channel_reg <= {{(7-CH_W){1'b0}}, idx_reg};
            m_value_reg   <= '0;
            m_otr_reg     <= 1'b0;
            m_hg_reg      <= rd_hg_vld_reg ? hg_rdata : '0;
            m_lg_reg      <= rd_lg_vld_reg ? lg_rdata : '0;
            m_last_reg    <= idx_last;
        end
    end

    // event id and STP registers only change when the output word is taken or empty
    assign m_valid         = m_valid_reg;
    assign m_kind          = m_kind_reg;
    assign m_channel       = m_channel_reg;
    assign m_value         = m_value_reg;
    assign m_out_of_range  = m_otr_reg;
    assign m_event_id      = cur_event_reg;
    assign m_hg_value      = m_hg_reg;
    assign m_lg_value      = m_lg_reg;
    assign m_stp_events    = stp_events_reg;
    assign m_stp_command   = stp_command_reg;
    assign m_stp_cycles    = stp_cycles_reg;
    assign m_stp_tdc_count = stp_tdc_reg;
    assign m_last          = m_last_reg;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for readout_word_decoder_unit. A queue of readout words
// (directed corner words, then random legacy and new-format events) feeds a
// clocked driver; every accepted word runs through a local decoder model that
// queues the result words it should produce, and a clocked monitor compares
// each result word field by field. Idle and stall rates rotate as the run goes.
// ----------------------------------------------------------------------------
module tb_top import rwd_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 2000;
    localparam int LEGACY_WORDS = 75;
    localparam int TOTAL_WORDS  = 170;
    localparam int PHASE_WORDS  = 24;

    // legacy corners: STP before any header, ADC/TDC/scaler extremes, STP overrun
    localparam logic [31:0] LEGACY_CASES [17] = '{
        32'hffffffff, 32'hff97ffff, 32'h00000000, 32'hff9fffff, 32'h00080000,
        32'h0ffff000, 32'h00201000, 32'hffbfffff, 32'h00200000, 32'hffbfefff,
        32'h00400000, 32'hffdfffff, 32'h0fffffff, 32'hff7fffff, 32'h00ffffff,
        32'hff6a5a5a, 32'h00600000
    };

    // new-format corners: headers, ADC, lead with bit 12 low, scaler, STP,
    // unknown in the ADC family, legacy header after the format switch
    localparam logic [31:0] NEW_CASES [9] = '{
        32'hff7c0000, 32'hc03fffff, 32'hc07fffff, 32'hc1000000, 32'hc2ffffff,
        32'hc3000000, 32'hc0800000, 32'h0ffff123, 32'hff7cffff
    };

    typedef struct {
        logic [31:0] raw;
        bit          drain;
    } word_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [6:0]  channel;
        logic [13:0] value;
        logic        out_of_range;
        logic [31:0] event_id;
        logic [11:0] hg_value;
        logic [11:0] lg_value;
        logic [11:0] stp_events;
        logic        stp_command;
        logic [23:0] stp_cycles;
        logic [23:0] stp_tdc_count;
        logic        last;
    } record_t;

    // clock, reset and block ports
    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_raw_word = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_kind;
    logic [6:0]  m_channel;
    logic [13:0] m_value;
    logic        m_out_of_range;
    logic [31:0] m_event_id;
    logic [11:0] m_hg_value;
    logic [11:0] m_lg_value;
    logic [11:0] m_stp_events;
    logic        m_stp_command;
    logic [23:0] m_stp_cycles;
    logic [23:0] m_stp_tdc_count;
    logic        m_last;

    // decoder model state
    bit          fmt_new   = 1'b0;
    logic [31:0] evt_next  = '0;
    logic [31:0] evt_cur   = '0;
    phase_t      stp_ph    = PH_FIRST;
    logic [11:0] stp_evt   = '0;
    logic        stp_cmd   = 1'b0;
    logic [23:0] stp_cyc   = '0;
    logic [23:0] stp_tdc   = '0;
    logic [11:0] hg_store [ADC_CHANNELS];
    logic [11:0] lg_store [ADC_CHANNELS];

    word_item_t word_queue[$];
    record_t    expected_records[$];

    int words_in     = 0;
    int records_seen = 0;
    int dumps        = 0;
    int fails        = 0;
    int quiet_cycles = 0;
    int idle_phase;
    int gap_pct   [4] = '{0, 45, 0, 32};
    int stall_pct [4] = '{0, 0, 45, 32};

    assign idle_phase = (words_in / PHASE_WORDS) % 4;

    always #5 aclk = ~aclk;

    readout_word_decoder_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_raw_word     (s_raw_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_channel      (m_channel),
        .m_value        (m_value),
        .m_out_of_range (m_out_of_range),
        .m_event_id     (m_event_id),
        .m_hg_value     (m_hg_value),
        .m_lg_value     (m_lg_value),
        .m_stp_events   (m_stp_events),
        .m_stp_command  (m_stp_command),
        .m_stp_cycles   (m_stp_cycles),
        .m_stp_tdc_count(m_stp_tdc_count),
        .m_last         (m_last)
    );

    function automatic logic [31:0] swap_bytes(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    // common fields: current event id and STP registers
    function automatic record_t fresh_record(input kind_t k);
        record_t r;
        r               = '0;
        r.kind          = k;
        r.event_id      = evt_cur;
        r.stp_events    = stp_evt;
        r.stp_command   = stp_cmd;
        r.stp_cycles    = stp_cyc;
        r.stp_tdc_count = stp_tdc;
        return r;
    endfunction

    // one record per ADC channel, both stores side by side
    task automatic emit_dump(input kind_t k);
        record_t r;
        for (int i = 0; i < ADC_CHANNELS; i++) begin
            r          = fresh_record(k);
            r.channel  = 7'(i);
            r.hg_value = hg_store[i];
            r.lg_value = lg_store[i];
            r.last     = (i == ADC_CHANNELS - 1);
            expected_records.insert(expected_records.size(), r);
        end
        dumps++;
    endtask

    // decode one accepted word, update model state, queue its result words
    task automatic decode_word(input logic [31:0] raw);
        logic [31:0] d;
        logic [5:0]  ach;
        bit          hdr_old, hdr_new, is_hg, is_lg, is_lead, is_trail, is_scal, is_stp;
        bit          one_word;
        kind_t       k;
        record_t     r;
        d        = swap_bytes(raw);
        hdr_old  = d[31:12] == 20'h0ffff;
        hdr_new  = d[31:16] == 16'hff7c;
        one_word = 1'b1;
        if (fmt_new) begin
            is_hg    = d[31:22] == {8'hc0, 2'b00};
            is_lg    = d[31:22] == {8'hc0, 2'b01};
            is_lead  = d[31:24] == 8'hc1;
            is_trail = 1'b0;
            is_scal  = d[31:24] == 8'hc2;
            is_stp   = d[31:24] == 8'hc3;
            ach      = d[21:16];
        end else begin
            is_hg    = d[22:21] == 2'b00 && !d[19];
            is_lg    = d[22:21] == 2'b00 && d[19];
            is_lead  = d[22:21] == 2'b01 && d[12];
            is_trail = d[22:21] == 2'b01 && !d[12];
            is_scal  = d[22:21] == 2'b10;
            is_stp   = d[22:21] == 2'b11;
            ach      = d[18:13];
        end

        if (hdr_old || hdr_new) begin
            // header: next event, STP assembly restarts
            if (hdr_new) fmt_new = 1'b1;
            evt_cur  = evt_next;
            evt_next = evt_next + 32'd1;
            stp_ph   = PH_FIRST;
            r        = fresh_record(hdr_old ? KIND_OLD_HDR : KIND_NEW_HDR);
            r.value  = {2'b00, d[11:0]};
        end else if (is_hg || is_lg) begin
            if (is_hg) hg_store[ach] = d[11:0];
            else       lg_store[ach] = d[11:0];
            r              = fresh_record(is_hg ? KIND_ADC_HG : KIND_ADC_LG);
            r.channel      = {1'b0, ach};
            r.value        = {2'b00, d[11:0]};
            r.out_of_range = d[12];
        end else if (is_lead || is_trail) begin
            r         = fresh_record(is_lead ? KIND_TDC_LEAD : KIND_TDC_TRL);
            r.channel = {1'b0, ach};
            r.value   = {2'b00, d[11:0]};
        end else if (is_scal) begin
            r         = fresh_record(KIND_SCALER);
            r.channel = fmt_new ? d[22:16] : d[20:14];
            r.value   = d[13:0];
        end else if (is_stp) begin
            // three-word STP assembly; anything past the third is an overrun
            case (stp_ph)
                PH_FIRST: begin
                    stp_evt = d[11:0];
                    stp_cmd = d[16];
                    stp_ph  = PH_SECOND;
                    k       = KIND_STP1;
                end
                PH_SECOND: begin
                    stp_cyc = d[23:0];
                    stp_ph  = PH_THIRD;
                    k       = KIND_STP2;
                end
                PH_THIRD: begin
                    stp_tdc = d[23:0];
                    stp_ph  = PH_DONE;
                    k       = KIND_STP3;
                end
                default: begin
                    k = KIND_STP_ERR;
                end
            endcase
            emit_dump(k);
            one_word = 1'b0;
        end else begin
            emit_dump(KIND_UNKNOWN);
            one_word = 1'b0;
        end

        if (one_word) begin
            r.last = 1'b1;
            expected_records.insert(expected_records.size(), r);
        end
    endtask

    // stimulus words are built in native order and sent big-endian
    task automatic add_word(input logic [31:0] native, input bit drain = 1'b0);
        word_item_t it;
        it.raw   = swap_bytes(native);
        it.drain = drain;
        word_queue.insert(word_queue.size(), it);
    endtask

    // number of STP words in an event: mostly three, some short, some overrun
    function automatic int stp_count();
        int sel;
        sel = $urandom_range(9);
        return (sel < 3) ? sel : (sel < 8) ? 3 : sel - 4;
    endfunction

    task automatic add_legacy_event();
        logic [31:0] d;
        int          n;
        add_word({20'h0ffff, 12'($urandom)}, $urandom_range(14) == 0);
        n = $urandom_range(5);
        repeat (n) begin
            d        = $urandom;
            d[22:21] = 2'b00;
            add_word(d);
        end
        n = $urandom_range(2);
        repeat (n) begin
            d        = $urandom;
            d[22:21] = 2'b01;
            add_word(d);
        end
        if ($urandom_range(1)) begin
            d        = $urandom;
            d[22:21] = 2'b10;
            add_word(d);
        end
        n = stp_count();
        repeat (n) begin
            d        = $urandom;
            d[22:21] = 2'b11;
            add_word(d);
        end
        if ($urandom_range(9) == 0) add_word($urandom);
    endtask

    task automatic add_new_event();
        logic [31:0] d;
        int          n;
        int          sel;
        d = $urandom;
        if ($urandom_range(4) == 0) d[31:12] = 20'h0ffff;
        else                        d[31:16] = 16'hff7c;
        add_word(d, $urandom_range(14) == 0);
        n = $urandom_range(6);
        repeat (n) begin
            d        = $urandom;
            d[31:23] = {8'hc0, 1'b0};
            add_word(d);
        end
        n = $urandom_range(2);
        repeat (n) begin
            d        = $urandom;
            d[31:24] = 8'hc1;
            add_word(d);
        end
        if ($urandom_range(1)) begin
            d        = $urandom;
            d[31:24] = 8'hc2;
            add_word(d);
        end
        n = stp_count();
        repeat (n) begin
            d        = $urandom;
            d[31:24] = 8'hc3;
            add_word(d);
        end
        // noise: any word, or the unused half of the ADC family
        sel = $urandom_range(9);
        if (sel == 0) begin
            add_word($urandom);
        end else if (sel == 1) begin
            d        = $urandom;
            d[31:23] = {8'hc0, 1'b1};
            add_word(d);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            fails++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
        end
    endtask

    // input driver: take words from the queue, hold each until accepted
    always @(posedge aclk) begin : drive
        word_item_t it;
        bit         present;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_raw_word <= '0;
        end else begin
            if (s_valid && s_ready) begin
                decode_word(s_raw_word);
                words_in++;
            end
            if (!s_valid || s_ready) begin
                present = word_queue.size() != 0
                       && $urandom_range(99) >= gap_pct[idle_phase]
                       && !(word_queue[0].drain && expected_records.size() != 0);
                if (present) begin
                    it         = word_queue.pop_front();
                    s_valid    <= 1'b1;
                    s_raw_word <= it.raw;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compare each accepted word with the oldest expectation
    always @(posedge aclk) begin : monitor
        record_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                records_seen++;
                if (expected_records.size() == 0) begin
                    fails++;
                    $error("result word with nothing expected, kind %0d", m_kind);
                end else begin
                    want = expected_records.pop_front();
                    check_field("kind", want.kind, m_kind);
                    check_field("channel", want.channel, m_channel);
                    check_field("value", want.value, m_value);
                    check_field("out_of_range", want.out_of_range, m_out_of_range);
                    check_field("event_id", want.event_id, m_event_id);
                    check_field("hg_value", want.hg_value, m_hg_value);
                    check_field("lg_value", want.lg_value, m_lg_value);
                    check_field("stp_events", want.stp_events, m_stp_events);
                    check_field("stp_command", want.stp_command, m_stp_command);
                    check_field("stp_cycles", want.stp_cycles, m_stp_cycles);
                    check_field("stp_tdc_count", want.stp_tdc_count, m_stp_tdc_count);
                    check_field("last", want.last, m_last);
                end
            end
            m_ready <= $urandom_range(99) >= stall_pct[idle_phase];
        end
    end

    // watchdog: no word moving on either side for too long
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        foreach (hg_store[i]) begin
            hg_store[i] = '0;
            lg_store[i] = '0;
        end

        // legacy format first; the format flag is sticky once set
        foreach (LEGACY_CASES[i]) add_word(LEGACY_CASES[i]);
        while (word_queue.size() < LEGACY_WORDS) add_legacy_event();
        // switch to new format only after the pipe has drained
        foreach (NEW_CASES[i]) add_word(NEW_CASES[i], i == 0);
        while (word_queue.size() < TOTAL_WORDS) add_new_event();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (word_queue.size() != 0 || s_valid) @(posedge aclk);
        while (expected_records.size() != 0) @(posedge aclk);
        // wait on to catch any result word beyond those expected
        repeat (300) @(posedge aclk);

        $display("tb_top: %0d words sent in legacy and new format, %0d result words checked",
                 words_in, records_seen);
        $display("tb_top: %0d store dumps incl. STP overruns and unknown words, %0d mismatches",
                 dumps, fails);
        if (fails == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
